// ===== hdl/bmsi_pkg.sv =====
// Shared types and constants for the banked mapper with scanline interrupt.
// Holds the bus operation codes, the region codes, register decode keys and
// the result record. Depends on nothing.
`default_nettype none

package bmsi_pkg;

    // Bus operation carried by each request
    typedef enum logic [2:0] {
        OP_CPU_WR = 3'd0,
        OP_CPU_RD = 3'd1,
        OP_PPU_RD = 3'd2,
        OP_PPU_WR = 3'd3,
        OP_TICK   = 3'd4
    } t_op;

    // Physical region hit by an access
    typedef enum logic [1:0] {
        REGION_NONE    = 2'd0,
        REGION_PRG_ROM = 2'd1,
        REGION_PRG_RAM = 2'd2,
        REGION_CHR     = 2'd3
    } t_region;

    // Mapper register key: {address[14:13], address[0]} of a cpu write at 0x8000 and up
    localparam logic [2:0] REG_SELECT     = 3'b000;
    localparam logic [2:0] REG_BANK_DATA  = 3'b001;
    localparam logic [2:0] REG_MIRROR     = 3'b010;
    localparam logic [2:0] REG_IRQ_VALUE  = 3'b100;
    localparam logic [2:0] REG_IRQ_RELOAD = 3'b101;
    localparam logic [2:0] REG_IRQ_OFF    = 3'b110;
    localparam logic [2:0] REG_IRQ_ON     = 3'b111;

    // Configuration register indexes on the APB port (byte address 4*index)
    localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
    localparam logic [1:0] CFG_CHR_COUNT = 2'd1;
    localparam logic [1:0] CFG_CHR_RAM   = 2'd2;

    // Configuration reset values
    localparam logic [6:0] PRG_COUNT_RESET = 7'd32;
    localparam logic [8:0] CHR_COUNT_RESET = 9'd128;

    // Width of a translated byte offset
    localparam int unsigned MEM_ADDR_W = 19;

    // One result
    typedef struct packed {
        t_region                 region;
        logic [MEM_ADDR_W-1:0]   mem_address;
        logic                    write_enable;
        logic [7:0]              write_byte;
        logic                    irq_line;
        logic                    mirror_horizontal;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/banked_mapper_with_scanline_irq_top.sv =====
// Top level of the banked mapper with scanline interrupt counter.
// Translates cpu and ppu bus requests into region offsets and runs the
// scanline counter. Depends on bmsi_pkg.
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ------------------------------------
//  request   in         i_in_valid / o_in_stall   i_operation, i_address, i_data_byte
//  result    out        o_out_valid / i_out_stall o_region, o_mem_address, o_write_enable,
//                                                 o_write_byte, o_irq_line,
//                                                 o_mirror_horizontal
//  config    in         APB psel / penable        paddr, pwdata, prdata, pready
//
// One request is taken per cycle while o_in_stall is low; its result goes to the output
// register, or to the skid stage while the output is stalled. The translation and the
// register updates are combinational between the request port and the result register.
// A one-entry skid stage behind the output register takes a result while the
// output is stalled; o_in_stall rises only when the skid stage is full.
// Reset (i_rst_n low, synchronous) clears the mapper state and loads the
// configuration defaults: 32 program banks, 128 character banks, character ROM.
`default_nettype none

module banked_mapper_with_scanline_irq_top #(
    parameter int unsigned PRG_RAM_BYTES = 8192,
    parameter int unsigned MAX_PRG_BANKS = 64,
    parameter int unsigned MAX_CHR_BANKS = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_operation,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_data_byte,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_region,
    output logic [18:0]      o_mem_address,
    output logic             o_write_enable,
    output logic [7:0]       o_write_byte,
    output logic             o_irq_line,
    output logic             o_mirror_horizontal,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [8:0]  MaxPrg  = 9'(MAX_PRG_BANKS);
    localparam logic [8:0]  MaxChr  = 9'(MAX_CHR_BANKS);
    localparam logic [18:0] RamMask = 19'(PRG_RAM_BYTES - 1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [6:0] r_prg_count;
    logic [8:0] r_chr_count;
    logic       r_chr_is_ram;
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    // Write the addressed register on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_count  <= bmsi_pkg::PRG_COUNT_RESET;
            r_chr_count  <= bmsi_pkg::CHR_COUNT_RESET;
            r_chr_is_ram <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                bmsi_pkg::CFG_PRG_COUNT: r_prg_count  <= pwdata[6:0];
                bmsi_pkg::CFG_CHR_COUNT: r_chr_count  <= pwdata[8:0];
                bmsi_pkg::CFG_CHR_RAM:   r_chr_is_ram <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        case (cfg_idx)
            bmsi_pkg::CFG_PRG_COUNT: prdata = {25'd0, r_prg_count};
            bmsi_pkg::CFG_CHR_COUNT: prdata = {23'd0, r_chr_count};
            bmsi_pkg::CFG_CHR_RAM:   prdata = {31'd0, r_chr_is_ram};
            default:                 prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Mapper state
    // ---------------------------------------------------------------
    logic [2:0] r_select_index, n_select_index;
    logic       r_prg_swap, n_prg_swap;
    logic       r_chr_invert, n_chr_invert;
    logic [7:0] r_bank [8];
    logic       bank_wr;
    logic       r_mirror, n_mirror;
    logic [7:0] r_irq_reload, n_irq_reload;
    logic [7:0] r_irq_counter, n_irq_counter;
    logic       r_reload_pending, n_reload_pending;
    logic       r_irq_enable, n_irq_enable;
    logic       r_irq_asserted, n_irq_asserted;

    // ---------------------------------------------------------------
    // Request handshake and output staging
    // ---------------------------------------------------------------
    bmsi_pkg::t_result r_out, r_skid, n_result;
    logic              r_out_valid, r_skid_valid;
    logic              in_accept, out_take, out_free;
    bmsi_pkg::t_op     op;

    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid & ~r_skid_valid;
    assign out_take   = r_out_valid & ~i_out_stall;
    assign out_free   = out_take | ~r_out_valid;
    assign op         = bmsi_pkg::t_op'(i_operation);

    // ---------------------------------------------------------------
    // Bank counts and masks
    // ---------------------------------------------------------------
    logic [8:0] prg_cnt, chr_cnt, prg_cnt_m1, chr_cnt_m1;
    logic [7:0] prg_mask, prg_last, prg_second, chr_mask;

    // Clamp counts to one .. maximum
    always_comb begin
        if (r_prg_count == 7'd0) begin
            prg_cnt = 9'd1;
        end else if ({2'd0, r_prg_count} > MaxPrg) begin
            prg_cnt = MaxPrg;
        end else begin
            prg_cnt = {2'd0, r_prg_count};
        end
        if (r_chr_count == 9'd0) begin
            chr_cnt = 9'd1;
        end else if (r_chr_count > MaxChr) begin
            chr_cnt = MaxChr;
        end else begin
            chr_cnt = r_chr_count;
        end
    end

    assign prg_cnt_m1 = prg_cnt - 9'd1;
    assign chr_cnt_m1 = chr_cnt - 9'd1;
    assign prg_mask   = prg_cnt_m1[7:0];
    assign prg_last   = prg_cnt_m1[7:0];
    assign prg_second = (prg_cnt >= 9'd2) ? (prg_last - 8'd1) : 8'd0;
    assign chr_mask   = chr_cnt_m1[7:0];

    // ---------------------------------------------------------------
    // Program window translation (8 KB windows from 0x8000)
    // ---------------------------------------------------------------
    logic [7:0]  prg_b6, prg_b7, prg_bank;
    logic [20:0] prg_full;

    assign prg_b6 = r_bank[6] & prg_mask;
    assign prg_b7 = r_bank[7] & prg_mask;

    always_comb begin
        case (i_address[14:13])
            2'd0:    prg_bank = r_prg_swap ? prg_second : prg_b6;
            2'd1:    prg_bank = prg_b7;
            2'd2:    prg_bank = r_prg_swap ? prg_b6 : prg_second;
            default: prg_bank = prg_last;
        endcase
    end

    assign prg_full = {prg_bank, i_address[12:0]};

    // ---------------------------------------------------------------
    // Character window translation (1 KB windows, inverted halves)
    // ---------------------------------------------------------------
    logic [2:0] chr_win, chr_sel;
    logic [7:0] chr_raw, chr_bank;

    assign chr_win = i_address[12:10] ^ {r_chr_invert, 2'b00};
    // 2 KB pairs use registers 0 and 1; 1 KB windows use registers 2 to 5
    assign chr_sel = chr_win[2] ? (chr_win - 3'd2) : {2'b00, chr_win[1]};
    assign chr_raw = r_bank[chr_sel];
    assign chr_bank = (chr_win[2] ? chr_raw : {chr_raw[7:1], chr_win[0]}) & chr_mask;

    // ---------------------------------------------------------------
    // Per-request decode: state updates and result
    // ---------------------------------------------------------------
    logic [2:0]  reg_key;
    logic [18:0] ram_off;
    logic        in_ram_window;

    assign reg_key       = {i_address[14:13], i_address[0]};
    assign ram_off       = {6'd0, i_address[12:0]} & RamMask;
    assign in_ram_window = (i_address[15:13] == 3'b011);

    always_comb begin
        n_select_index   = r_select_index;
        n_prg_swap       = r_prg_swap;
        n_chr_invert     = r_chr_invert;
        bank_wr          = 1'b0;
        n_mirror         = r_mirror;
        n_irq_reload     = r_irq_reload;
        n_irq_counter    = r_irq_counter;
        n_reload_pending = r_reload_pending;
        n_irq_enable     = r_irq_enable;
        n_irq_asserted   = r_irq_asserted;

        n_result.region       = bmsi_pkg::REGION_NONE;
        n_result.mem_address  = '0;
        n_result.write_enable = 1'b0;

        case (op)
            bmsi_pkg::OP_CPU_WR: begin
                if (in_ram_window) begin
                    n_result.region       = bmsi_pkg::REGION_PRG_RAM;
                    n_result.mem_address  = ram_off;
                    n_result.write_enable = 1'b1;
                end else if (i_address[15]) begin
                    // Mapper register write
                    case (reg_key)
                        bmsi_pkg::REG_SELECT: begin
                            n_select_index = i_data_byte[2:0];
                            n_prg_swap     = i_data_byte[6];
                            n_chr_invert   = i_data_byte[7];
                        end
                        bmsi_pkg::REG_BANK_DATA:  bank_wr = 1'b1;
                        bmsi_pkg::REG_MIRROR:     n_mirror = i_data_byte[0];
                        bmsi_pkg::REG_IRQ_VALUE:  n_irq_reload = i_data_byte;
                        bmsi_pkg::REG_IRQ_RELOAD: begin
                            n_irq_counter    = 8'd0;
                            n_reload_pending = 1'b1;
                        end
                        bmsi_pkg::REG_IRQ_OFF: begin
                            n_irq_enable   = 1'b0;
                            n_irq_asserted = 1'b0;
                        end
                        bmsi_pkg::REG_IRQ_ON:     n_irq_enable = 1'b1;
                        default: ;
                    endcase
                end
            end
            bmsi_pkg::OP_CPU_RD: begin
                if (i_address[15]) begin
                    n_result.region      = bmsi_pkg::REGION_PRG_ROM;
                    n_result.mem_address = prg_full[18:0];
                end else if (in_ram_window) begin
                    n_result.region      = bmsi_pkg::REGION_PRG_RAM;
                    n_result.mem_address = ram_off;
                end
            end
            bmsi_pkg::OP_PPU_RD, bmsi_pkg::OP_PPU_WR: begin
                n_result.region       = bmsi_pkg::REGION_CHR;
                n_result.mem_address  = {1'b0, chr_bank, i_address[9:0]};
                n_result.write_enable = (op == bmsi_pkg::OP_PPU_WR) & r_chr_is_ram;
            end
            bmsi_pkg::OP_TICK: begin
                // Reload on zero or on request, else count down
                if ((r_irq_counter == 8'd0) || r_reload_pending) begin
                    n_irq_counter    = r_irq_reload;
                    n_reload_pending = 1'b0;
                end else begin
                    n_irq_counter = r_irq_counter - 8'd1;
                    if ((r_irq_counter == 8'd1) && r_irq_enable) begin
                        n_irq_asserted = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        n_result.write_byte        = n_result.write_enable ? i_data_byte : 8'd0;
        n_result.irq_line          = n_irq_asserted;
        n_result.mirror_horizontal = n_mirror;
    end

    // Advance the mapper state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_select_index   <= 3'd0;
            r_prg_swap       <= 1'b0;
            r_chr_invert     <= 1'b0;
            r_mirror         <= 1'b0;
            r_irq_reload     <= 8'd0;
            r_irq_counter    <= 8'd0;
            r_reload_pending <= 1'b0;
            r_irq_enable     <= 1'b0;
            r_irq_asserted   <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_bank[i] <= 8'd0;
            end
        end else if (in_accept) begin
            r_select_index   <= n_select_index;
            r_prg_swap       <= n_prg_swap;
            r_chr_invert     <= n_chr_invert;
            r_mirror         <= n_mirror;
            r_irq_reload     <= n_irq_reload;
            r_irq_counter    <= n_irq_counter;
            r_reload_pending <= n_reload_pending;
            r_irq_enable     <= n_irq_enable;
            r_irq_asserted   <= n_irq_asserted;
            if (bank_wr) begin
                r_bank[r_select_index] <= i_data_byte;
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register and skid stage
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // Refill the output from the skid stage first, else from the request
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_accept;
            end
        end else if (in_accept) begin
            // Output held: park the new result
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= n_result;
            end
        end else if (in_accept) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_region            = r_out.region;
    assign o_mem_address       = r_out.mem_address;
    assign o_write_enable      = r_out.write_enable;
    assign o_write_byte        = r_out.write_byte;
    assign o_irq_line          = r_out.irq_line;
    assign o_mirror_horizontal = r_out.mirror_horizontal;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // A parked result implies a stalled output ahead of it
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a result with the output register empty");

    // The interrupt is raised only by a scanline tick
    a_irq_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_irq_asserted) |-> $past(in_accept && (op == bmsi_pkg::OP_TICK)))
        else $error("interrupt raised without a scanline tick");

    // A write strobe always names a real region
    a_we_has_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.write_enable) |-> (r_out.region != bmsi_pkg::REGION_NONE))
        else $error("write enable with no region");

    // A full skid stage drops out only by moving into a free output
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_stall) |=> r_skid_valid)
        else $error("parked result lost while output stalled");

endmodule

`default_nettype wire
